// ===== rtl/core/timed_task_release_queue_assert.svh =====
`ifndef TIMED_TASK_RELEASE_QUEUE_ASSERT_SVH
`define TIMED_TASK_RELEASE_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TTRQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttrq assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TTRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttrq assertion failed");

`endif

// ===== rtl/core/ttrq_pkg.sv =====
package ttrq_pkg;

   localparam int MODE_W  = 2;
   localparam int ID_W    = 8;
   localparam int DELAY_W = 8;
   localparam int PEND_W  = 5;

   localparam int TASK_SLOTS_DEFAULT = 16;
   localparam int CALL_SLOTS_DEFAULT = 16;

   localparam int CMD_DEPTH = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD_TASK = 2'd0,
      MODE_ADD_CALL = 2'd1,
      MODE_TICK     = 2'd2,
      MODE_TAKE     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ADD_TASK,
      OP_ADD_CALL,
      OP_TICK,
      OP_TAKE
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_TICK
   } state_type;

   typedef struct packed {
      op_type               op;
      logic [ID_W-1:0]      id;
      logic [DELAY_W-1:0]   delay;
   } cmd_type;

endpackage

// ===== rtl/core/ttrq_req_if.sv =====
interface ttrq_req_if;
   import ttrq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [ID_W-1:0]      task_id;
   logic [DELAY_W-1:0]   delay;

   modport source (output valid, mode, task_id, delay, input ready);
   modport sink (input valid, mode, task_id, delay, output ready);
endinterface

// ===== rtl/core/ttrq_rsp_if.sv =====
interface ttrq_rsp_if;
   import ttrq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 status;
   logic [ID_W-1:0]      dispatched_id;
   logic [PEND_W-1:0]    pending_calls;
   logic [PEND_W-1:0]    pending_tasks;

   modport source (output valid, status, dispatched_id, pending_calls, pending_tasks,
                   input ready);
   modport sink (input valid, status, dispatched_id, pending_calls, pending_tasks,
                 output ready);
endinterface

// ===== rtl/core/timed_task_release_queue.sv =====
// Channel   Dir  Transfer moves
// req_chan  in   mode, task_id, delay
// rsp_chan  out  status, dispatched_id, pending_calls, pending_tasks
//
// A request is registered in the command queue before the back end takes it.
// Adds finish in the idle state, a take of a waiting call passes the pop state, and
// a tick reads the live table entries in turn, set by the single table read port.
// Reset is synchronous and empties the table, the call FIFO and the command queue.
// Until full, the command queue accepts while the back end works or a reply stalls.
module timed_task_release_queue #(
   parameter int TASK_SLOTS = ttrq_pkg::TASK_SLOTS_DEFAULT,
   parameter int CALL_SLOTS = ttrq_pkg::CALL_SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ttrq_req_if.sink   req_chan,
   ttrq_rsp_if.source rsp_chan
);
   import ttrq_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   ttrq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   ttrq_back #(
      .TASK_SLOTS (TASK_SLOTS),
      .CALL_SLOTS (CALL_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_chan  (rsp_chan)
   );
endmodule

// ===== rtl/core/ttrq_front.sv =====
module ttrq_front (
   input  logic              clock,
   input  logic              reset,
   ttrq_req_if.sink          req_chan,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output ttrq_pkg::cmd_type cmd
);
   import ttrq_pkg::*;

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            queue_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_type            classified;
   logic               push;
   logic               pop;

   always_comb begin
      classified.id    = req_chan.task_id;
      classified.delay = req_chan.delay;
      unique case (mode_type'(req_chan.mode))
         MODE_ADD_TASK: classified.op = (req_chan.task_id != '0) ? OP_ADD_TASK : OP_NOP;
         MODE_ADD_CALL: classified.op = (req_chan.task_id != '0) ? OP_ADD_CALL : OP_NOP;
         MODE_TICK:     classified.op = OP_TICK;
         MODE_TAKE:     classified.op = OP_TAKE;
         default:       classified.op = OP_NOP;
      endcase
   end

   assign req_chan.ready = (count_ff != CNT_W'(CMD_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (count_ff != '0);
   assign pop            = cmd_valid && cmd_ready;
   assign cmd            = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end
endmodule

// ===== rtl/core/ttrq_back.sv =====
module ttrq_back #(
   parameter int TASK_SLOTS = ttrq_pkg::TASK_SLOTS_DEFAULT,
   parameter int CALL_SLOTS = ttrq_pkg::CALL_SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  ttrq_pkg::cmd_type cmd,
   ttrq_rsp_if.source        rsp_chan
);
   import ttrq_pkg::*;

   localparam int TIDX_W = $clog2(TASK_SLOTS);
   localparam int TCNT_W = $clog2(TASK_SLOTS + 1);
   localparam int CIDX_W = $clog2(CALL_SLOTS);
   localparam int CCNT_W = $clog2(CALL_SLOTS + 1);
   localparam int SUM_W  = CCNT_W + 1;

   state_type            state_ff, state_in;
   logic [TCNT_W-1:0]    tcount_ff, tcount_in;
   logic [TIDX_W-1:0]    idx_ff, idx_in;
   logic [TCNT_W-1:0]    wr_ff, wr_in;
   logic                 lost_ff, lost_in;
   logic [CIDX_W-1:0]    head_ff, head_in;
   logic [CCNT_W-1:0]    ccount_ff, ccount_in;

   logic [ID_W-1:0]      tid_mem [TASK_SLOTS];
   logic [DELAY_W-1:0]   tdly_mem [TASK_SLOTS];
   logic [ID_W-1:0]      tid_q;
   logic [DELAY_W-1:0]   tdly_q;
   logic [TIDX_W-1:0]    t_raddr;
   logic                 t_we;
   logic [TIDX_W-1:0]    t_waddr;
   logic [ID_W-1:0]      t_wid;
   logic [DELAY_W-1:0]   t_wdly;

   logic [ID_W-1:0]      fifo_mem [CALL_SLOTS];
   logic [ID_W-1:0]      pop_q;
   logic                 f_we;
   logic [ID_W-1:0]      f_wdata;
   logic [CIDX_W-1:0]    f_waddr;
   logic [SUM_W-1:0]     tail_sum;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [PEND_W-1:0]    rsp_calls_ff, rsp_calls_in;
   logic [PEND_W-1:0]    rsp_tasks_ff, rsp_tasks_in;

   logic                 take;
   logic                 fifo_full;
   logic                 fifo_empty;
   logic                 table_full;
   logic                 last_entry;
   logic [TIDX_W-1:0]    next_idx;
   logic                 push_req;
   logic [ID_W-1:0]      push_id;
   logic                 push_lost;
   logic                 load;
   logic                 load_status;
   logic [ID_W-1:0]      load_id;

   assign cmd_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign take       = cmd_valid && cmd_ready;
   assign fifo_full  = (ccount_ff == CCNT_W'(CALL_SLOTS));
   assign fifo_empty = (ccount_ff == '0);
   assign table_full = (tcount_ff == TCNT_W'(TASK_SLOTS));
   assign last_entry = ((TCNT_W'(idx_ff) + TCNT_W'(1)) == tcount_ff);
   assign next_idx   = last_entry ? '0 : TIDX_W'(idx_ff + 1'b1);
   assign tail_sum   = SUM_W'(head_ff) + SUM_W'(ccount_ff);
   assign f_waddr    = (tail_sum >= SUM_W'(CALL_SLOTS)) ?
                       CIDX_W'(tail_sum - SUM_W'(CALL_SLOTS)) : CIDX_W'(tail_sum);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && cmd.op == OP_TICK && tcount_ff != '0) begin
               state_in = ST_TICK;
            end else if (take && cmd.op == OP_TAKE && !fifo_empty) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            if (last_entry) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      tcount_in   = tcount_ff;
      idx_in      = idx_ff;
      wr_in       = wr_ff;
      lost_in     = lost_ff;
      head_in     = head_ff;
      ccount_in   = ccount_ff;
      t_raddr     = '0;
      t_we        = 1'b0;
      t_waddr     = tcount_ff[TIDX_W-1:0];
      t_wid       = cmd.id;
      t_wdly      = cmd.delay;
      push_req    = 1'b0;
      push_id     = cmd.id;
      load        = 1'b0;
      load_status = 1'b0;
      load_id     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (cmd.op)
                  OP_ADD_TASK: begin
                     load = 1'b1;
                     if (table_full) begin
                        load_status = 1'b1;
                     end else begin
                        t_we      = 1'b1;
                        tcount_in = TCNT_W'(tcount_ff + 1'b1);
                     end
                  end
                  OP_ADD_CALL: begin
                     load     = 1'b1;
                     push_req = 1'b1;
                  end
                  OP_TICK: begin
                     idx_in  = '0;
                     wr_in   = '0;
                     lost_in = 1'b0;
                     if (tcount_ff == '0) begin
                        load = 1'b1;
                     end
                  end
                  OP_TAKE: begin
                     if (fifo_empty) begin
                        load = 1'b1;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            load      = 1'b1;
            load_id   = pop_q;
            head_in   = (head_ff == CIDX_W'(CALL_SLOTS - 1)) ? '0 : CIDX_W'(head_ff + 1'b1);
            ccount_in = CCNT_W'(ccount_ff - 1'b1);
         end
         ST_TICK: begin
            if (tdly_q != '0) begin
               t_we    = 1'b1;
               t_waddr = wr_ff[TIDX_W-1:0];
               t_wid   = tid_q;
               t_wdly  = DELAY_W'(tdly_q - 1'b1);
               wr_in   = TCNT_W'(wr_ff + 1'b1);
            end else begin
               push_req = 1'b1;
               push_id  = tid_q;
            end
            idx_in  = next_idx;
            t_raddr = next_idx;
         end
         default: begin
         end
      endcase

      push_lost = push_req && fifo_full;
      f_we      = push_req && !fifo_full;
      f_wdata   = push_id;
      if (f_we) begin
         ccount_in = CCNT_W'(ccount_ff + 1'b1);
      end

      if (state_ff == ST_TICK) begin
         lost_in = lost_ff || push_lost;
         if (last_entry) begin
            tcount_in   = wr_in;
            load        = 1'b1;
            load_status = lost_in;
         end
      end else if (push_lost) begin
         load_status = 1'b1;
      end

      rsp_valid_in  = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      rsp_status_in = load ? load_status : rsp_status_ff;
      rsp_id_in     = load ? load_id : rsp_id_ff;
      rsp_calls_in  = load ? PEND_W'(ccount_in) : rsp_calls_ff;
      rsp_tasks_in  = load ? PEND_W'(tcount_in) : rsp_tasks_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tcount_ff    <= '0;
         idx_ff       <= '0;
         wr_ff        <= '0;
         lost_ff      <= 1'b0;
         head_ff      <= '0;
         ccount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tcount_ff    <= tcount_in;
         idx_ff       <= idx_in;
         wr_ff        <= wr_in;
         lost_ff      <= lost_in;
         head_ff      <= head_in;
         ccount_ff    <= ccount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_calls_ff  <= rsp_calls_in;
      rsp_tasks_ff  <= rsp_tasks_in;
   end

   always_ff @(posedge clock) begin
      if (t_we) begin
         tid_mem[t_waddr]  <= t_wid;
         tdly_mem[t_waddr] <= t_wdly;
      end
      tid_q  <= tid_mem[t_raddr];
      tdly_q <= tdly_mem[t_raddr];
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         fifo_mem[f_waddr] <= f_wdata;
      end
      pop_q <= fifo_mem[head_ff];
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.dispatched_id = rsp_id_ff;
   assign rsp_chan.pending_calls = rsp_calls_ff;
   assign rsp_chan.pending_tasks = rsp_tasks_ff;
endmodule

// ===== rtl/core/ttrq_checker.sv =====
`include "timed_task_release_queue_assert.svh"

module ttrq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_status,
   input logic [ttrq_pkg::ID_W-1:0] rsp_dispatched_id
);
   import ttrq_pkg::*;

   localparam int MAX_OUTST = CMD_DEPTH + 2;
   localparam int OUT_W     = $clog2(MAX_OUTST + 2);

   logic [OUT_W-1:0] outst_ff, outst_in;
   logic             req_xfer;
   logic             rsp_xfer;
   logic             rsp_stalled;
   logic             rsp_overflow;

   assign req_xfer     = req_valid && req_ready;
   assign rsp_xfer     = rsp_valid && rsp_ready;
   assign rsp_stalled  = rsp_valid && !rsp_ready;
   assign rsp_overflow = rsp_valid && rsp_status;

   always_comb begin
      outst_in = outst_ff;
      if (req_xfer && !rsp_xfer) begin
         outst_in = OUT_W'(outst_ff + 1'b1);
      end else if (rsp_xfer && !req_xfer) begin
         outst_in = OUT_W'(outst_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   `TTRQ_ASSERT_IMPLY(a_outst_bound, clock, reset, 1'b1, outst_ff <= OUT_W'(MAX_OUTST))
   `TTRQ_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, outst_ff != '0)
   `TTRQ_ASSERT_IMPLY(a_overflow_no_id, clock, reset, rsp_overflow, rsp_dispatched_id == '0)
   `TTRQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_status))
   `TTRQ_ASSERT_NEXT(a_rsp_hold_id, clock, reset, rsp_stalled, $stable(rsp_dispatched_id))
endmodule

bind timed_task_release_queue ttrq_checker u_ttrq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_dispatched_id (rsp_chan.dispatched_id)
);

// ===== tb/release_queue_checker.sv =====
module release_queue_checker #(
   parameter int TASK_SLOTS = ttrq_pkg::TASK_SLOTS_DEFAULT,
   parameter int CALL_SLOTS = ttrq_pkg::CALL_SLOTS_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   ttrq_req_if   req_chan,
   ttrq_rsp_if   rsp_chan,
   output int    mismatches,
   output int    awaiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import ttrq_pkg::*;

   typedef struct packed {
      logic                status;
      logic [ID_W-1:0]     dispatched_id;
      logic [PEND_W-1:0]   pending_calls;
      logic [PEND_W-1:0]   pending_tasks;
   } release_result_type;

   logic [ID_W-1:0]    task_ids [TASK_SLOTS];
   logic [DELAY_W-1:0] task_waits [TASK_SLOTS];
   int unsigned        task_total;
   logic [ID_W-1:0]    call_ring [CALL_SLOTS];
   int unsigned        call_head;
   int unsigned        call_total;

   release_result_type awaited_results [$];

   task automatic report(string what, int got, int want);
      if (mismatches < 40) begin
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
      mismatches++;
   endtask

   function automatic bit push_call(logic [ID_W-1:0] id);
      if (call_total >= CALL_SLOTS) begin
         return 1'b0;
      end
      call_ring[(call_head + call_total) % CALL_SLOTS] = id;
      call_total++;
      return 1'b1;
   endfunction

   function automatic release_result_type predict_release(mode_type mode,
                                                           logic [ID_W-1:0] id,
                                                           logic [DELAY_W-1:0] dly);
      release_result_type r;
      int unsigned        kept;
      r = '0;
      case (mode)
         MODE_ADD_TASK: begin
            if (id != 0) begin
               if (task_total < TASK_SLOTS) begin
                  task_ids[task_total] = id;
                  task_waits[task_total] = dly;
                  task_total++;
               end else begin
                  r.status = 1'b1;
               end
            end
         end
         MODE_ADD_CALL: begin
            if (id != 0 && !push_call(id)) begin
               r.status = 1'b1;
            end
         end
         MODE_TICK: begin
            // A task whose wait has run out moves to the call FIFO even when
            // the FIFO is full; its call is then lost.
            kept = 0;
            for (int i = 0; i < task_total; i++) begin
               if (task_waits[i] != 0) begin
                  task_ids[kept] = task_ids[i];
                  task_waits[kept] = task_waits[i] - 1'b1;
                  kept++;
               end else if (!push_call(task_ids[i])) begin
                  r.status = 1'b1;
               end
            end
            task_total = kept;
         end
         default: begin
            if (call_total != 0) begin
               r.dispatched_id = call_ring[call_head];
               call_head = (call_head + 1) % CALL_SLOTS;
               call_total--;
            end
         end
      endcase
      r.pending_calls = PEND_W'(call_total);
      r.pending_tasks = PEND_W'(task_total);
      return r;
   endfunction

   always @(posedge clock) begin
      release_result_type want;
      if (reset) begin
         task_total = 0;
         call_head = 0;
         call_total = 0;
         awaited_results.delete();
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
               report("response with no request outstanding", rsp_chan.dispatched_id, -1);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_chan.status !== want.status) begin
                  report("status", rsp_chan.status, want.status);
               end
               if (rsp_chan.dispatched_id !== want.dispatched_id) begin
                  report("dispatched_id", rsp_chan.dispatched_id, want.dispatched_id);
               end
               if (rsp_chan.pending_calls !== want.pending_calls) begin
                  report("pending_calls", rsp_chan.pending_calls, want.pending_calls);
               end
               if (rsp_chan.pending_tasks !== want.pending_tasks) begin
                  report("pending_tasks", rsp_chan.pending_tasks, want.pending_tasks);
               end
            end
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            awaited_results.push_back(predict_release(mode_type'(req_chan.mode),
                                                      req_chan.task_id, req_chan.delay));
         end
      end
      awaiting = awaited_results.size();
   end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ttrq_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   sent = 0;
   int   mismatches;
   int   awaiting;

   ttrq_req_if req_chan();
   ttrq_rsp_if rsp_chan();

   timed_task_release_queue DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   release_queue_checker watch (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99, 0) >= stall_pct);
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [ID_W-1:0] random_id();
      return ($urandom_range(15, 0) == 0) ? '0 : ID_W'($urandom_range(255, 1));
   endfunction

   function automatic logic [DELAY_W-1:0] random_delay();
      return ($urandom_range(39, 0) == 0) ? DELAY_W'($urandom_range(255, 0))
                                          : DELAY_W'($urandom_range(4, 0));
   endfunction

   // Called on a rising edge; returns on the edge at which the transfer happens.
   task automatic send_request(mode_type mode, logic [ID_W-1:0] id,
                               logic [DELAY_W-1:0] dly);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.mode    <= mode;
      req_chan.task_id <= id;
      req_chan.delay   <= dly;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sent++;
   endtask

   task automatic send_random(mode_type mode);
      send_request(mode, random_id(), random_delay());
   endtask

   // Adds calls and tasks up to or past the store sizes, then ticks so that released tasks can hit a full FIFO.
   task automatic release_storm();
      repeat ($urandom_range(16, 10)) send_request(MODE_ADD_CALL,
                                                    ID_W'($urandom_range(255, 1)),
                                                    DELAY_W'($urandom_range(255, 0)));
      repeat ($urandom_range(17, 8)) send_request(MODE_ADD_TASK,
                                                   ID_W'($urandom_range(255, 1)),
                                                   DELAY_W'($urandom_range(1, 0)));
      repeat (2) send_random(MODE_TICK);
      repeat ($urandom_range(20, 10)) send_random(MODE_TAKE);
   endtask

   task automatic run_episode();
      int kind;
      int len;
      int roll;
      int add_task_cut;
      int add_call_cut;
      int tick_cut;
      kind = $urandom_range(9, 0);
      if (kind == 0) begin
         release_storm();
      end else begin
         if (kind <= 3) begin
            add_task_cut = 30; add_call_cut = 50; tick_cut = 70;
         end else if (kind <= 6) begin
            add_task_cut = 45; add_call_cut = 80; tick_cut = 85;
         end else begin
            add_task_cut = 10; add_call_cut = 15; tick_cut = 55;
         end
         len = $urandom_range(60, 20);
         repeat (len) begin
            roll = $urandom_range(99, 0);
            if (roll < add_task_cut) begin
               send_random(MODE_ADD_TASK);
            end else if (roll < add_call_cut) begin
               send_random(MODE_ADD_CALL);
            end else if (roll < tick_cut) begin
               send_request(MODE_TICK, ID_W'($urandom_range(255, 0)),
                            DELAY_W'($urandom_range(255, 0)));
            end else begin
               send_request(MODE_TAKE, ID_W'($urandom_range(255, 0)),
                            DELAY_W'($urandom_range(255, 0)));
            end
         end
      end
   endtask

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.mode    <= MODE_ADD_TASK;
      req_chan.task_id <= '0;
      req_chan.delay   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_request(MODE_TAKE, 8'hFF, 8'hFF);
      send_request(MODE_TICK, 8'hFF, 8'hFF);
      send_request(MODE_ADD_TASK, 8'h00, 8'h09);
      send_request(MODE_ADD_CALL, 8'h00, 8'h00);
      send_request(MODE_ADD_TASK, 8'hFF, 8'h00);
      send_request(MODE_ADD_TASK, 8'h01, 8'hFF);
      send_request(MODE_ADD_TASK, 8'hAA, 8'h01);
      send_request(MODE_ADD_CALL, 8'h55, 8'hAA);
      send_request(MODE_TICK, 8'h00, 8'h00);
      send_request(MODE_TICK, 8'h5A, 8'hA5);
      repeat (4) send_request(MODE_TAKE, 8'h00, 8'h00);
      send_request(MODE_ADD_CALL, 8'hFF, 8'h00);
      send_request(MODE_ADD_CALL, 8'h01, 8'h00);
      repeat (2) send_request(MODE_TAKE, 8'h00, 8'h00);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 69; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 29; stall_pct = 29; end
         endcase
         if (phase == 0) begin
            release_storm();
         end
         while (sent < (phase + 1) * 300) begin
            run_episode();
         end
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (awaiting == 0);
      repeat (64) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ttrq_pkg.sv
rtl/core/ttrq_req_if.sv
rtl/core/ttrq_rsp_if.sv
rtl/core/ttrq_front.sv
rtl/core/ttrq_back.sv
rtl/core/timed_task_release_queue.sv
rtl/core/ttrq_checker.sv
tb/release_queue_checker.sv
tb/tb_top.sv
